// File: hw/rtl/literal_line_substitution_unit_macros.svh
// Assertion macros for the literal line substitution unit
// Expects i_clk and i_rst_n in the scope of every module that uses them
`ifndef LITERAL_LINE_SUBSTITUTION_UNIT_MACROS_SVH
`define LITERAL_LINE_SUBSTITUTION_UNIT_MACROS_SVH

// condition in this cycle implies consequence in this cycle
`define LLS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lls check failed: same-cycle implication");

// condition in this cycle implies consequence in the next cycle
`define LLS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lls check failed: next-cycle implication");

`endif

// File: hw/rtl/lls_pkg.sv
// Package for the literal line substitution unit: types, codes and defaults
// No dependencies; used by every module of the unit
package lls_pkg;

    // default sizes, handed to the top level parameters
    localparam int MAX_PATTERN_DEF     = 8;
    localparam int MAX_REPLACEMENT_DEF = 8;
    localparam int LINE_DEPTH_DEF      = 4096;

    // fixed field widths
    localparam int CFG_W = 64;
    localparam int LEN_W = 4;

    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

    // eight bytes, byte zero in the low bits
    typedef logic [7:0][7:0] t_bytes8;

    typedef enum logic [1:0] {
        K_BYTE = 2'd0,
        K_END  = 2'd1,
        K_PULL = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_UNMOD = 2'd0,
        ST_MOD   = 2'd1,
        ST_OVF   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CFG_PATTERN   = 2'd0,
        CFG_PAT_LEN   = 2'd1,
        CFG_REPLACE   = 2'd2,
        CFG_REP_LEN   = 2'd3
    } t_cfg_index;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TRIM,
        S_REPL,
        S_FLUSH,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] content_byte;
        logic       has_newline;
    } t_in;

    typedef struct packed {
        logic       out_kind;
        logic [7:0] out_byte;
        logic       last;
        logic [1:0] record_status;
    } t_out;

    // window commands from the sequencer
    typedef struct packed {
        logic append;
        logic pop;
        logic clear;
    } t_win_cmd;

endpackage

// File: hw/rtl/lls_window.sv
// Match window of the literal line substitution unit: byte shift line and compare
// Depends on lls_pkg
module lls_window #(
    parameter int MAX_PATTERN = lls_pkg::MAX_PATTERN_DEF,
    localparam int CW = $clog2(MAX_PATTERN + 1),
    localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lls_pkg::t_win_cmd i_cmd,
    input  logic [7:0]        i_byte,
    input  logic [CW-1:0]     i_plen,
    input  lls_pkg::t_bytes8  i_pattern,
    output logic [CW-1:0]     o_count,
    output logic [7:0]        o_oldest,
    output logic              o_match
);

    logic [7:0]    r_win [MAX_PATTERN];
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    // fill count
    always_comb begin
        n_count = r_count;
        if (i_cmd.clear) begin
            n_count = '0;
        end else if (i_cmd.append) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // window bytes, oldest at entry zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.append) begin
            r_win[r_count[IW-1:0]] <= i_byte;
        end else if (i_cmd.pop) begin
            for (int i = 0; i < MAX_PATTERN - 1; i++) begin
                r_win[i] <= r_win[i + 1];
            end
        end
    end

    // compare the first plen bytes against the pattern
    always_comb begin
        o_match = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if ((CW'(i) < i_plen) && (r_win[i] != i_pattern[i])) begin
                o_match = 1'b0;
            end
        end
    end

    assign o_count  = r_count;
    assign o_oldest = r_win[0];

endmodule

// File: hw/rtl/lls_line_store.sv
// Line store of the literal line substitution unit: one write and one read port
// Depends on lls_pkg only through its parameter default
module lls_line_store #(
    parameter int LINE_DEPTH = lls_pkg::LINE_DEPTH_DEF,
    localparam int AW = $clog2(LINE_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [LINE_DEPTH];
    logic [7:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hw/rtl/lls_ctrl.sv
// Sequencer of the literal line substitution unit: drives the window, the store
// write unit and the result register. Depends on lls_pkg and the macro header
`include "literal_line_substitution_unit_macros.svh"

module lls_ctrl #(
    parameter int MAX_PATTERN = lls_pkg::MAX_PATTERN_DEF,
    parameter int LINE_DEPTH  = lls_pkg::LINE_DEPTH_DEF,
    localparam int CW = $clog2(MAX_PATTERN + 1),
    localparam int AW = $clog2(LINE_DEPTH),
    localparam int LW = $clog2(LINE_DEPTH + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  lls_pkg::t_in             i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output lls_pkg::t_out            o_out_data,
    input  logic [CW-1:0]            i_plen,
    input  logic [lls_pkg::LEN_W-1:0] i_rlen,
    input  lls_pkg::t_bytes8         i_replace,
    output lls_pkg::t_win_cmd        o_win_cmd,
    output logic [7:0]               o_win_byte,
    input  logic [CW-1:0]            i_win_count,
    input  logic [7:0]               i_win_oldest,
    input  logic                     i_win_match,
    output logic                     o_wr_en,
    output logic [AW-1:0]            o_wr_addr,
    output logic [7:0]               o_wr_data,
    output logic                     o_rd_en,
    output logic [AW-1:0]            o_rd_addr,
    input  logic [7:0]               i_rd_data
);

    lls_pkg::t_state r_state, n_state;

    logic [LW-1:0]             r_line_len, n_line_len;
    logic [LW-1:0]             r_rd_pos, n_rd_pos;
    logic                      r_matched, n_matched;
    logic                      r_overflow, n_overflow;
    logic                      r_held, n_held;
    logic                      r_nl_pending, n_nl_pending;
    logic [lls_pkg::LEN_W-1:0] r_rep_idx, n_rep_idx;
    logic                      r_has_nl, n_has_nl;
    logic                      r_pull_nl, n_pull_nl;
    logic                      r_out_valid, n_out_valid;
    lls_pkg::t_out             r_out_data, n_out_data;

    logic            in_xfer;
    logic            out_xfer;
    logic            st_req;
    logic [7:0]      st_byte;
    logic            fin;
    lls_pkg::t_status status;

    assign o_in_stall = (r_state != lls_pkg::S_IDLE) || r_out_valid;
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign out_xfer   = r_out_valid && !i_out_stall;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lls_pkg::S_IDLE: begin
                if (in_xfer) begin
                    case (i_in_data.kind)
                        lls_pkg::K_BYTE: n_state = lls_pkg::S_TRIM;
                        lls_pkg::K_END:  n_state = lls_pkg::S_FLUSH;
                        lls_pkg::K_PULL: begin
                            if (r_held) begin
                                n_state = lls_pkg::S_EMIT;
                            end
                        end
                        default: n_state = lls_pkg::S_IDLE;
                    endcase
                end
            end
            lls_pkg::S_TRIM: begin
                if (i_win_count > i_plen) begin
                    n_state = lls_pkg::S_TRIM;
                end else if ((i_win_count == i_plen) && i_win_match && (i_rlen != '0)) begin
                    n_state = lls_pkg::S_REPL;
                end else begin
                    n_state = lls_pkg::S_IDLE;
                end
            end
            lls_pkg::S_REPL: begin
                if (r_rep_idx == i_rlen - lls_pkg::LEN_W'(1)) begin
                    n_state = lls_pkg::S_IDLE;
                end
            end
            lls_pkg::S_FLUSH: begin
                if (i_win_count == '0) begin
                    n_state = lls_pkg::S_IDLE;
                end
            end
            lls_pkg::S_EMIT: n_state = lls_pkg::S_IDLE;
            default: n_state = lls_pkg::S_IDLE;
        endcase
    end

    // datapath control and register next values
    always_comb begin
        n_line_len   = r_line_len;
        n_rd_pos     = r_rd_pos;
        n_matched    = r_matched;
        n_overflow   = r_overflow;
        n_held       = r_held;
        n_nl_pending = r_nl_pending;
        n_rep_idx    = r_rep_idx;
        n_has_nl     = r_has_nl;
        n_pull_nl    = r_pull_nl;
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        o_win_cmd    = '0;
        o_rd_en      = 1'b0;
        o_wr_en      = 1'b0;
        st_req       = 1'b0;
        st_byte      = i_win_oldest;
        fin          = 1'b0;
        status       = lls_pkg::ST_UNMOD;

        if (out_xfer) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            lls_pkg::S_IDLE: begin
                if (in_xfer) begin
                    case (i_in_data.kind)
                        lls_pkg::K_BYTE, lls_pkg::K_END: begin
                            // a new record drops unread output
                            if (r_held) begin
                                n_held       = 1'b0;
                                n_line_len   = '0;
                                n_rd_pos     = '0;
                                n_nl_pending = 1'b0;
                            end
                            if (i_in_data.kind == lls_pkg::K_BYTE) begin
                                o_win_cmd.append = 1'b1;
                            end else begin
                                n_has_nl = i_in_data.has_newline;
                            end
                        end
                        lls_pkg::K_PULL: begin
                            if (r_held) begin
                                o_rd_en   = 1'b1;
                                n_pull_nl = !(r_rd_pos < r_line_len);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            lls_pkg::S_TRIM: begin
                if (i_win_count > i_plen) begin
                    o_win_cmd.pop = 1'b1;
                    st_req        = 1'b1;
                end else if (i_win_count == i_plen) begin
                    if (i_win_match) begin
                        o_win_cmd.clear = 1'b1;
                        n_matched       = 1'b1;
                        n_rep_idx       = '0;
                    end else begin
                        o_win_cmd.pop = 1'b1;
                        st_req        = 1'b1;
                    end
                end
            end
            lls_pkg::S_REPL: begin
                st_req    = 1'b1;
                st_byte   = i_replace[r_rep_idx[2:0]];
                n_rep_idx = r_rep_idx + lls_pkg::LEN_W'(1);
            end
            lls_pkg::S_FLUSH: begin
                if (i_win_count != '0) begin
                    o_win_cmd.pop = 1'b1;
                    st_req        = 1'b1;
                end else begin
                    // record status and line hand-over
                    if (r_overflow) begin
                        status = lls_pkg::ST_OVF;
                    end else if (r_matched) begin
                        status = lls_pkg::ST_MOD;
                    end else begin
                        status = lls_pkg::ST_UNMOD;
                    end
                    n_rd_pos = '0;
                    if (status == lls_pkg::ST_MOD) begin
                        n_nl_pending = r_has_nl;
                        n_held       = (r_line_len != '0) || r_has_nl;
                        if (!((r_line_len != '0) || r_has_nl)) begin
                            n_line_len = '0;
                        end
                    end else begin
                        n_line_len   = '0;
                        n_nl_pending = 1'b0;
                    end
                    n_matched                = 1'b0;
                    n_overflow               = 1'b0;
                    n_out_valid              = 1'b1;
                    n_out_data.out_kind      = 1'b1;
                    n_out_data.out_byte      = 8'h00;
                    n_out_data.last          = 1'b0;
                    n_out_data.record_status = status;
                end
            end
            lls_pkg::S_EMIT: begin
                if (r_pull_nl) begin
                    n_out_data.out_byte = lls_pkg::NEWLINE_BYTE;
                    fin                 = 1'b1;
                end else begin
                    n_out_data.out_byte = i_rd_data;
                    n_rd_pos            = r_rd_pos + LW'(1);
                    fin = ((r_rd_pos + LW'(1)) >= r_line_len) && !r_nl_pending;
                end
                if (fin) begin
                    n_held       = 1'b0;
                    n_line_len   = '0;
                    n_rd_pos     = '0;
                    n_nl_pending = 1'b0;
                end
                n_out_valid              = 1'b1;
                n_out_data.out_kind      = 1'b0;
                n_out_data.last          = fin;
                n_out_data.record_status = lls_pkg::ST_UNMOD;
            end
            default: ;
        endcase

        // shared store write unit, one byte per cycle
        if (st_req) begin
            if (r_line_len < LW'(LINE_DEPTH)) begin
                o_wr_en    = 1'b1;
                n_line_len = r_line_len + LW'(1);
            end else begin
                n_overflow = 1'b1;
            end
        end
    end

    assign o_wr_addr   = r_line_len[AW-1:0];
    assign o_wr_data   = st_byte;
    assign o_rd_addr   = r_rd_pos[AW-1:0];
    assign o_win_byte  = i_in_data.content_byte;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= lls_pkg::S_IDLE;
            r_line_len   <= '0;
            r_rd_pos     <= '0;
            r_matched    <= 1'b0;
            r_overflow   <= 1'b0;
            r_held       <= 1'b0;
            r_nl_pending <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_line_len   <= n_line_len;
            r_rd_pos     <= n_rd_pos;
            r_matched    <= n_matched;
            r_overflow   <= n_overflow;
            r_held       <= n_held;
            r_nl_pending <= n_nl_pending;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rep_idx  <= n_rep_idx;
        r_has_nl   <= n_has_nl;
        r_pull_nl  <= n_pull_nl;
        r_out_data <= n_out_data;
    end

    // checks
    `LLS_ASSERT_IMPL(a_win_bound, 1'b1, i_win_count <= CW'(MAX_PATTERN))
    `LLS_ASSERT_IMPL(a_len_bound, 1'b1, r_line_len <= LW'(LINE_DEPTH))
    `LLS_ASSERT_IMPL(a_repl_matched, r_state == lls_pkg::S_REPL, r_matched)
    `LLS_ASSERT_IMPL(a_read_bound, r_held, r_rd_pos <= r_line_len)
    `LLS_ASSERT_NEXT(a_emit_loads, r_state == lls_pkg::S_EMIT, r_out_valid && !r_out_data.out_kind)

endmodule

// File: hw/rtl/literal_line_substitution_unit.sv
// Top level of the literal line substitution unit: configuration registers and
// the sequencer, match window and line store. Depends on lls_pkg and its modules
//
// Items are taken one at a time; o_in_stall stays high while an item is in work
// and while a result waits in the output register. A content byte enters the
// window, then each byte that drops out of the window ahead of the compare (up
// to seven after the pattern length shrinks) is written to the line, and on a
// match each replacement byte is written in turn.
// End of record writes each byte left in the window to the line and then
// yields the status result; a pull that finds a held line yields its next
// output byte, any other pull or an unused kind does nothing.
// Every byte that enters the line, passed through or replaced, goes through the
// single write port of the line store, one byte at a time.
// Configuration writes are taken at any time but are meant for idle periods.
module literal_line_substitution_unit #(
    parameter int MAX_PATTERN     = lls_pkg::MAX_PATTERN_DEF,
    parameter int MAX_REPLACEMENT = lls_pkg::MAX_REPLACEMENT_DEF,
    parameter int LINE_DEPTH      = lls_pkg::LINE_DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  lls_pkg::t_in              i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output lls_pkg::t_out             o_out_data,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_index,
    input  logic [lls_pkg::CFG_W-1:0] i_cfg_data
);

    localparam int CW = $clog2(MAX_PATTERN + 1);
    localparam int AW = $clog2(LINE_DEPTH);

    lls_pkg::t_bytes8          r_pattern;
    lls_pkg::t_bytes8          r_replace;
    logic [lls_pkg::LEN_W-1:0] r_pat_len;
    logic [lls_pkg::LEN_W-1:0] r_rep_len;
    logic [lls_pkg::LEN_W-1:0] plen_clamp;
    logic [lls_pkg::LEN_W-1:0] rlen_eff;
    logic [CW-1:0]             plen_eff;

    lls_pkg::t_win_cmd win_cmd;
    logic [7:0]        win_byte;
    logic [CW-1:0]     win_count;
    logic [7:0]        win_oldest;
    logic              win_match;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [7:0]        rd_data;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_pat_len <= lls_pkg::LEN_W'(1);
            r_replace <= '0;
            r_rep_len <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lls_pkg::CFG_PATTERN: r_pattern <= i_cfg_data;
                lls_pkg::CFG_PAT_LEN: r_pat_len <= i_cfg_data[lls_pkg::LEN_W-1:0];
                lls_pkg::CFG_REPLACE: r_replace <= i_cfg_data;
                lls_pkg::CFG_REP_LEN: r_rep_len <= i_cfg_data[lls_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // effective lengths: zero pattern length acts as one, both clamp to maximum
    always_comb begin
        if (r_pat_len == '0) begin
            plen_clamp = lls_pkg::LEN_W'(1);
        end else if (r_pat_len > lls_pkg::LEN_W'(MAX_PATTERN)) begin
            plen_clamp = lls_pkg::LEN_W'(MAX_PATTERN);
        end else begin
            plen_clamp = r_pat_len;
        end
        if (r_rep_len > lls_pkg::LEN_W'(MAX_REPLACEMENT)) begin
            rlen_eff = lls_pkg::LEN_W'(MAX_REPLACEMENT);
        end else begin
            rlen_eff = r_rep_len;
        end
    end

    assign plen_eff = plen_clamp[CW-1:0];

    lls_ctrl #(
        .MAX_PATTERN (MAX_PATTERN),
        .LINE_DEPTH  (LINE_DEPTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_data   (o_out_data),
        .i_plen       (plen_eff),
        .i_rlen       (rlen_eff),
        .i_replace    (r_replace),
        .o_win_cmd    (win_cmd),
        .o_win_byte   (win_byte),
        .i_win_count  (win_count),
        .i_win_oldest (win_oldest),
        .i_win_match  (win_match),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data)
    );

    lls_window #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (win_cmd),
        .i_byte    (win_byte),
        .i_plen    (plen_eff),
        .i_pattern (r_pattern),
        .o_count   (win_count),
        .o_oldest  (win_oldest),
        .o_match   (win_match)
    );

    lls_line_store #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

endmodule
